>>> hw/rtl/dvm_pkg.sv
// dvm_pkg.sv: shared types and constants of the varint id matcher
`timescale 1ns / 1ps
`default_nettype none
package dvm_pkg;

   localparam int BYTE_W     = 8;
   localparam int TARGET_W   = 63;
   localparam int POS_W      = 64;
   localparam int GRP_W      = 4;
   localparam int SHAMT_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_ADDR = 3'd0;

   // last varint group that still lands inside the 64-bit position
   localparam logic [GRP_W-1:0] GRP_LIVE_MAX = 4'd9;
   localparam logic [BYTE_W-1:0] ID_TERM     = 8'h00;

   localparam logic KIND_MATCH    = 1'b0;
   localparam logic KIND_NOTFOUND = 1'b1;

   typedef enum logic [3:0] {
      PH_VARINT = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_STREAM = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] id_char;
      logic              kind;
      logic              final_flag;
   } res_type;

endpackage
`default_nettype wire

>>> hw/rtl/dvm_if.sv
// dvm_if.sv: valid/ready word channels of the varint id matcher
`timescale 1ns / 1ps
`default_nettype none
interface dvm_req_if import dvm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dvm_rsp_if import dvm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] id_char;
   logic              kind;
   logic              final_flag;

   modport source (output valid, output id_char, output kind, output final_flag, input ready);
   modport sink   (input valid, input id_char, input kind, input final_flag, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dvm_scan.sv
// dvm_scan.sv: bucket scan state and per-byte decode, match and result logic
`timescale 1ns / 1ps
`default_nettype none
module dvm_scan import dvm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [BYTE_W-1:0]   data_byte,
   input  wire logic                last_byte,
   input  wire logic [TARGET_W-1:0] target,
   output res_type                  res
);

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic              match_ff, match_in;

   logic               grp_live;
   logic [SHAMT_W-1:0] shamt;
   logic [POS_W-1:0]   addend;
   logic [POS_W-1:0]   pos_sum;
   logic               hit;
   res_type            res_c;

   assign grp_live = (grp_ff <= GRP_LIVE_MAX);
   assign shamt    = SHAMT_W'({2'b00, grp_ff} * 6'd7);
   assign addend   = grp_live ? ({{(POS_W-7){1'b0}}, data_byte[6:0]} << shamt) : '0;
   assign pos_sum  = pos_ff + addend;
   assign hit      = (pos_sum == {1'b0, target});

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      grp_in   = grp_ff;
      match_in = match_ff;
      res_c    = '0;
      case (phase_ff)
         PH_VARINT: begin
            pos_in = pos_sum;
            if (data_byte[7]) begin
               if (grp_live) begin
                  grp_in = grp_ff + 4'd1;
               end
            end else begin
               grp_in = '0;
               if (hit) begin
                  phase_in = PH_STREAM;
                  match_in = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (data_byte == ID_TERM) begin
               phase_in = PH_VARINT;
            end
         end
         PH_STREAM: begin
            res_c.valid      = 1'b1;
            res_c.id_char    = data_byte;
            res_c.kind       = KIND_MATCH;
            res_c.final_flag = (data_byte == ID_TERM);
            if (data_byte == ID_TERM) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      if (last_byte) begin
         if (!match_in) begin
            res_c.valid      = 1'b1;
            res_c.id_char    = ID_TERM;
            res_c.kind       = KIND_NOTFOUND;
            res_c.final_flag = 1'b1;
         end else if (phase_in == PH_STREAM) begin
            if (!res_c.valid) begin
               res_c.valid   = 1'b1;
               res_c.id_char = ID_TERM;
               res_c.kind    = KIND_MATCH;
            end
            res_c.final_flag = 1'b1;
         end
         phase_in = PH_VARINT;
         pos_in   = '0;
         grp_in   = '0;
         match_in = 1'b0;
      end
   end

   assign res = step ? res_c : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VARINT;
         pos_ff   <= '0;
         grp_ff   <= '0;
         match_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         grp_ff   <= grp_in;
         match_ff <= match_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/delta_varint_id_matcher.sv
// delta_varint_id_matcher.sv: top level of the varint delta id matcher
//
//  port   dir   handshake            word
//  req    in    valid/ready          data_byte[7:0], last_byte
//  rsp    out   valid/ready          id_char[7:0], kind, final_flag
//  csr    in    apb, pready always 1 target_position at byte address 0
//
//  one byte per cycle sustained while rsp is not stalled; input register then result register
//  a byte's word passes from req through the input register and then the result register to rsp
//  cycle time is set by the varint shift, add and compare between the two registers
//  a stalled rsp holds the byte in the input register; req drops ready only then
//  synchronous reset clears scan state, valids and target_position
`timescale 1ns / 1ps
`default_nettype none
module delta_varint_id_matcher import dvm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dvm_req_if.sink                    req,
   dvm_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_char_ff;
   logic                rsp_kind_ff;
   logic                rsp_final_ff;
   logic [TARGET_W-1:0] target_ff, target_in;

   logic    req_fire;
   logic    out_free;
   logic    advance;
   logic    csr_wr;
   res_type res;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_TARGET_ADDR);
   assign target_in  = csr_pwdata[TARGET_W-1:0];
   assign csr_prdata = (csr_paddr == CSR_TARGET_ADDR) ? {1'b0, target_ff} : '0;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? res.valid : (rsp_valid_ff && !rsp.ready);

   dvm_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .target    (target_ff),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            target_ff <= target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
      if (advance && res.valid) begin
         rsp_char_ff  <= res.id_char;
         rsp_kind_ff  <= res.kind;
         rsp_final_ff <= res.final_flag;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.id_char    = rsp_char_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.final_flag = rsp_final_ff;

endmodule
`default_nettype wire

>>> hw/rtl/dvm_checker.sv
// dvm_checker.sv: port-level checks of the varint id matcher and their binding
`timescale 1ns / 1ps
`default_nettype none
module dvm_checker import dvm_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_id_char,
   input wire logic              rsp_kind,
   input wire logic              rsp_final_flag
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id_char)
         && $stable(rsp_kind) && $stable(rsp_final_flag))
      else $error("rsp word changed while stalled");

   // not-found always ends the run with a null char
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NOTFOUND) |-> rsp_final_flag && (rsp_id_char == ID_TERM))
      else $error("not-found word malformed");

   // an id terminator always closes the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MATCH) && (rsp_id_char == ID_TERM) |-> rsp_final_flag)
      else $error("id terminator without final flag");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind delta_varint_id_matcher dvm_checker u_dvm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_id_char    (rsp.id_char),
   .rsp_kind       (rsp.kind),
   .rsp_final_flag (rsp.final_flag)
);
`default_nettype wire

>>> sim/delta_varint_id_matcher_test.sv
// regression bench for the varint delta id matcher: directed buckets, random buckets, scoreboard
`timescale 1ns / 1ps
module delta_varint_id_matcher_test;
   import dvm_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] id_char;
      logic              kind;
      logic              final_flag;
   } id_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dvm_req_if req_if ();
   dvm_rsp_if rsp_if ();

   delta_varint_id_matcher uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // scan state mirrored from the block
   logic [TARGET_W-1:0] target_pos = '0;
   logic [POS_W-1:0]    scan_pos = '0;
   logic [6:0]          scan_shift = '0;
   phase_type           scan_phase = PH_VARINT;
   logic                scan_hit = 1'b0;

   id_word_type       pending_words[$];
   logic [BYTE_W-1:0] bucket_bytes[$];
   int                fail_count = 0;
   bit                steady_flow = 1'b0;

   function automatic void predict_scan(input logic [BYTE_W-1:0] b, input logic lst);
      id_word_type w;
      logic        got;
      got = 1'b0;
      w = '0;
      case (scan_phase)
         PH_VARINT: begin
            if (scan_shift < 7'd64)
               scan_pos += 64'(b[6:0]) << scan_shift;
            if (b[7]) begin
               if (scan_shift < 7'd64)
                  scan_shift += 7'd7;
            end else begin
               scan_shift = '0;
               if (scan_pos == {1'b0, target_pos}) begin
                  scan_phase = PH_STREAM;
                  scan_hit = 1'b1;
               end else begin
                  scan_phase = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (b == ID_TERM)
               scan_phase = PH_VARINT;
         end
         PH_STREAM: begin
            got = 1'b1;
            w.id_char = b;
            w.kind = KIND_MATCH;
            w.final_flag = (b == ID_TERM);
            if (b == ID_TERM)
               scan_phase = PH_DONE;
         end
         default: ;
      endcase
      if (lst) begin
         if (!scan_hit) begin
            got = 1'b1;
            w.id_char = ID_TERM;
            w.kind = KIND_NOTFOUND;
            w.final_flag = 1'b1;
         end else if (scan_phase == PH_STREAM) begin
            if (got) begin
               w.final_flag = 1'b1;
            end else begin
               got = 1'b1;
               w.id_char = ID_TERM;
               w.kind = KIND_MATCH;
               w.final_flag = 1'b1;
            end
         end
         scan_pos = '0;
         scan_shift = '0;
         scan_phase = PH_VARINT;
         scan_hit = 1'b0;
      end
      if (got)
         pending_words.push_back(w);
   endfunction

   // result side: random back-pressure (none while steady_flow) and the scoreboard
   always @(posedge clock) begin
      id_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word id_char %h kind %b final %b", $time,
                     rsp_if.id_char, rsp_if.kind, rsp_if.final_flag);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.id_char !== want.id_char) begin
               $display("%0t: id_char expected %h actual %h", $time, want.id_char,
                        rsp_if.id_char);
               fail_count++;
            end
            if (rsp_if.kind !== want.kind) begin
               $display("%0t: kind expected %b actual %b", $time, want.kind, rsp_if.kind);
               fail_count++;
            end
            if (rsp_if.final_flag !== want.final_flag) begin
               $display("%0t: final_flag expected %b actual %b", $time, want.final_flag,
                        rsp_if.final_flag);
               fail_count++;
            end
         end
      end
      rsp_if.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 18);
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= lst;
      do @(posedge clock); while (!req_if.ready);
      predict_scan(b, lst);
      while (!steady_flow && $urandom_range(99) < 18) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_bucket();
      foreach (bucket_bytes[i])
         send_byte(bucket_bytes[i], i == bucket_bytes.size() - 1);
   endtask

   // target changes only once the block has drained
   task automatic write_target(input logic [CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_TARGET_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      target_pos = value[TARGET_W-1:0];
   endtask

   task automatic push_varint(input logic [POS_W-1:0] delta);
      int          ngrp;
      int          total;
      logic [6:0]  grp;
      logic [31:0] noise;
      ngrp = 1;
      for (int k = 1; k < 10; k++)
         if ((delta >> (7 * k)) != 0)
            ngrp = k + 1;
      total = ngrp + (($urandom_range(9) == 0) ? $urandom_range(1, 11) : 0);
      for (int k = 0; k < total; k++) begin
         noise = $urandom;
         if (k < 9)
            grp = 7'(delta >> (7 * k));
         else if (k == 9)
            grp = {noise[5:0], delta[63]};
         else
            grp = noise[6:0];
         bucket_bytes.push_back({k != total - 1, grp});
      end
   endtask

   task automatic make_bucket();
      int               style;
      int               n_ent;
      int               hit;
      int               keep;
      logic [POS_W-1:0] gpos;
      logic [POS_W-1:0] delta;
      bucket_bytes.delete();
      style = $urandom_range(99);
      if (style < 8) begin
         repeat ($urandom_range(1, 12)) bucket_bytes.push_back(8'($urandom));
      end else begin
         n_ent = $urandom_range(1, 6);
         hit = $urandom_range(0, n_ent + 1);
         gpos = '0;
         for (int e = 0; e < n_ent; e++) begin
            if (e == hit || $urandom_range(15) == 0)
               delta = {1'b0, target_pos} - gpos;
            else if ($urandom_range(9) == 0)
               delta = {$urandom, $urandom};
            else
               delta = 64'($urandom_range(0, 20));
            push_varint(delta);
            gpos += delta;
            repeat ($urandom_range(0, 6)) bucket_bytes.push_back(8'($urandom_range(1, 255)));
            bucket_bytes.push_back(ID_TERM);
         end
         if (style < 20) begin
            keep = $urandom_range(1, bucket_bytes.size());
            while (bucket_bytes.size() > keep) void'(bucket_bytes.pop_back());
         end
      end
   endtask

   task automatic test_reset_target();
      bucket_bytes = '{8'h00, 8'h41, 8'hff, 8'h00};
      send_bucket();
   endtask

   task automatic test_first_match_only();
      write_target(64'd5);
      bucket_bytes = '{8'h03, 8'h78, 8'h00, 8'h02, 8'h80, 8'h00, 8'h00, 8'h71, 8'h00};
      send_bucket();
      bucket_bytes = '{8'h01, 8'h61, 8'h00};
      send_bucket();
      bucket_bytes = '{8'h85};
      send_bucket();
   endtask

   task automatic test_truncated_match();
      write_target(64'h8000_0000_0000_0007);
      bucket_bytes = '{8'h07};
      send_bucket();
      bucket_bytes = '{8'h07, 8'h68, 8'h69};
      send_bucket();
   endtask

   task automatic test_long_varint();
      write_target(64'h7fff_ffff_ffff_ffff);
      bucket_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                       8'h00, 8'h7a, 8'h00};
      send_bucket();
      write_target(64'd0);
      bucket_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                       8'hff, 8'h01, 8'h00, 8'h01, 8'h61, 8'h00};
      send_bucket();
   endtask

   task automatic test_random_buckets(input logic [CSR_DATA_W-1:0] target, input int n_items,
                                      input bit no_gaps);
      int sent;
      write_target(target);
      steady_flow = no_gaps;
      sent = 0;
      while (sent < n_items) begin
         make_bucket();
         send_bucket();
         sent += bucket_bytes.size();
         if ($urandom_range(29) == 0) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_words.size() != 0);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_target();
      test_first_match_only();
      test_truncated_match();
      test_long_varint();
      test_random_buckets(64'($urandom_range(0, 40)), 250, 1'b0);
      test_random_buckets(64'd0, 150, 1'b1);
      test_random_buckets(64'h7fff_ffff_ffff_ffff, 150, 1'b0);
      test_random_buckets({$urandom, $urandom}, 150, 1'b0);
      test_random_buckets({1'b1, 57'd0, 6'($urandom_range(0, 30))}, 150, 1'b0);
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("delta_varint_id_matcher regression: pass");
      else
         $display("delta_varint_id_matcher regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("delta_varint_id_matcher regression: fail");
      $finish;
   end

endmodule
